// ===== rtl/sdi_pkg.sv =====
`default_nettype none
package sdi_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 4;
    localparam int unsigned TRIES_W    = 4;
    localparam int unsigned RCA_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OP_COND_TRIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_ENABLE   = 1'd1;

    localparam logic [TRIES_W-1:0] TRIES_RESET = 4'd10;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DONE  = 1'b1;

    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_ALL_CID    = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
    localparam logic [5:0] CMD_SET_BUS    = 6'd6;
    localparam logic [5:0] CMD_SELECT     = 6'd7;
    localparam logic [5:0] CMD_IF_COND    = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
    localparam logic [5:0] CMD_OP_COND    = 6'd41;
    localparam logic [5:0] CMD_APP        = 6'd55;

    localparam logic [31:0] IF_COND_ARG  = 32'h0000_01AA;
    localparam logic [31:0] OCR_VOLTS    = 32'h0030_0000;
    localparam logic [31:0] OCR_HCS_BIT  = 32'h4000_0000;
    localparam int unsigned OCR_BUSY_POS = 31;
    localparam int unsigned OCR_HCS_POS  = 30;
    localparam logic [31:0] BUS4_ARG     = 32'h0000_0002;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_VOLTAGE  = 2'd1;
    localparam logic [1:0] ST_NO_READY = 2'd2;

    typedef enum logic [10:0] {
        PH_IDLE = 11'b000_0000_0001,
        PH_CMD0 = 11'b000_0000_0010,
        PH_CMD8 = 11'b000_0000_0100,
        PH_APP  = 11'b000_0000_1000,
        PH_OPC  = 11'b000_0001_0000,
        PH_CID  = 11'b000_0010_0000,
        PH_RCA  = 11'b000_0100_0000,
        PH_CSD  = 11'b000_1000_0000,
        PH_SEL  = 11'b001_0000_0000,
        PH_WAPP = 11'b010_0000_0000,
        PH_WBUS = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic        req_type;
        logic        timed_out;
        logic [31:0] resp_word;
    } t_req;

    typedef struct packed {
        logic [5:0]       cmd_index;
        logic [31:0]      cmd_arg;
        logic             expect_resp;
        logic             long_resp;
        logic             finished;
        logic [1:0]       status;
        logic             high_capacity;
        logic [RCA_W-1:0] card_rca;
        logic             bus_wide;
    } t_rsp;

    typedef struct packed {
        t_phase             phase;
        logic [TRIES_W-1:0] tries_left;
        logic               capacity_flag;
        logic [RCA_W-1:0]   rca;
        logic               wide_flag;
    } t_state;

    typedef struct packed {
        logic [TRIES_W-1:0] op_cond_tries;
        logic               wide_enable;
    } t_cfg;

endpackage
`default_nettype wire

// ===== rtl/sdi_req_if.sv =====
`default_nettype none
interface sdi_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        timed_out;
    logic [31:0] resp_word;

    modport source (output valid, output req_type, output timed_out, output resp_word,
                    input ready);
    modport sink (input valid, input req_type, input timed_out, input resp_word,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/sdi_rsp_if.sv =====
`default_nettype none
interface sdi_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic        expect_resp;
    logic        long_resp;
    logic        finished;
    logic [1:0]  status;
    logic        high_capacity;
    logic [15:0] card_rca;
    logic        bus_wide;

    modport source (output valid, output cmd_index, output cmd_arg, output expect_resp,
                    output long_resp, output finished, output status,
                    output high_capacity, output card_rca, output bus_wide,
                    input ready);
    modport sink (input valid, input cmd_index, input cmd_arg, input expect_resp,
                  input long_resp, input finished, input status,
                  input high_capacity, input card_rca, input bus_wide,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/sdi_in_reg.sv =====
`default_nettype none
module sdi_in_reg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sdi_req_if.sink          i_req,
    input  wire logic        i_adv,
    output sdi_pkg::t_req    o_word,
    output logic             o_vld
);
    import sdi_pkg::*;

    logic r_vld;
    t_req r_word;
    logic w_take;

    assign i_req.ready = !r_vld || i_adv;
    assign w_take      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_word <= '{req_type: i_req.req_type, timed_out: i_req.timed_out,
                        resp_word: i_req.resp_word};
        end
    end

    assign o_word = r_word;
    assign o_vld  = r_vld;
endmodule
`default_nettype wire

// ===== rtl/sdi_step.sv =====
`default_nettype none
module sdi_step (
    input  wire sdi_pkg::t_req   i_word,
    input  wire sdi_pkg::t_state i_st,
    input  wire sdi_pkg::t_cfg   i_cfg,
    output sdi_pkg::t_state      o_st,
    output sdi_pkg::t_rsp        o_rsp,
    output logic                 o_has_rsp
);
    import sdi_pkg::*;

    logic [31:0]        w_r;
    logic [31:0]        w_rca_arg;
    logic [TRIES_W-1:0] w_dec;
    t_state             n_st;
    logic               n_has;
    logic [5:0]         n_idx;
    logic [31:0]        n_arg;
    logic               n_exp;
    logic               n_long;
    logic               n_fin;
    logic [1:0]         n_status;

    assign w_r       = i_word.timed_out ? '0 : i_word.resp_word;
    assign w_rca_arg = {i_st.rca, 16'h0000};
    assign w_dec     = (i_st.tries_left == '0) ? '0 : i_st.tries_left - 1'b1;

    always_comb begin
        n_st     = i_st;
        n_has    = 1'b1;
        n_idx    = CMD_GO_IDLE;
        n_arg    = '0;
        n_exp    = 1'b1;
        n_long   = 1'b0;
        n_fin    = 1'b0;
        n_status = ST_OK;
        if (i_word.req_type == REQ_START) begin
            n_st.capacity_flag = 1'b0;
            n_st.rca           = '0;
            n_st.wide_flag     = 1'b0;
            n_st.tries_left    = '0;
            n_st.phase         = PH_CMD0;
            n_exp              = 1'b0;
        end else begin
            case (i_st.phase)
                PH_CMD0: begin
                    n_st.phase = PH_CMD8;
                    n_idx      = CMD_IF_COND;
                    n_arg      = IF_COND_ARG;
                end
                PH_CMD8: begin
                    n_st.capacity_flag = (w_r != '0);
                    if (w_r != '0 && w_r != IF_COND_ARG) begin
                        n_st.phase = PH_IDLE;
                        n_fin      = 1'b1;
                        n_status   = ST_VOLTAGE;
                    end else begin
                        n_st.tries_left = (i_cfg.op_cond_tries == '0) ?
                                          TRIES_W'(1) : i_cfg.op_cond_tries;
                        n_st.phase      = PH_APP;
                        n_idx           = CMD_APP;
                    end
                end
                PH_APP: begin
                    n_st.phase = PH_OPC;
                    n_idx      = CMD_OP_COND;
                    n_arg      = i_st.capacity_flag ? (OCR_VOLTS | OCR_HCS_BIT) : OCR_VOLTS;
                end
                PH_OPC: begin
                    if (w_r[OCR_BUSY_POS]) begin
                        if (!w_r[OCR_HCS_POS]) begin
                            n_st.capacity_flag = 1'b0;
                        end
                        n_st.phase = PH_CID;
                        n_idx      = CMD_ALL_CID;
                        n_long     = 1'b1;
                    end else begin
                        n_st.tries_left = w_dec;
                        if (w_dec == '0) begin
                            n_st.phase = PH_IDLE;
                            n_fin      = 1'b1;
                            n_status   = ST_NO_READY;
                        end else begin
                            n_st.phase = PH_APP;
                            n_idx      = CMD_APP;
                        end
                    end
                end
                PH_CID: begin
                    n_st.phase = PH_RCA;
                    n_idx      = CMD_SEND_RCA;
                end
                PH_RCA: begin
                    n_st.rca   = w_r[31:16];
                    n_st.phase = PH_CSD;
                    n_idx      = CMD_SEND_CSD;
                    n_arg      = {w_r[31:16], 16'h0000};
                    n_long     = 1'b1;
                end
                PH_CSD: begin
                    n_st.phase = PH_SEL;
                    n_idx      = CMD_SELECT;
                    n_arg      = w_rca_arg;
                end
                PH_SEL: begin
                    if (i_cfg.wide_enable) begin
                        n_st.phase = PH_WAPP;
                        n_idx      = CMD_APP;
                        n_arg      = w_rca_arg;
                    end else begin
                        n_st.wide_flag = 1'b0;
                        n_st.phase     = PH_IDLE;
                        n_fin          = 1'b1;
                    end
                end
                PH_WAPP: begin
                    n_st.phase = PH_WBUS;
                    n_idx      = CMD_SET_BUS;
                    n_arg      = BUS4_ARG;
                end
                PH_WBUS: begin
                    n_st.wide_flag = 1'b1;
                    n_st.phase     = PH_IDLE;
                    n_fin          = 1'b1;
                end
                default: begin
                    n_has = 1'b0;
                end
            endcase
        end
        if (n_fin) begin
            n_idx  = CMD_GO_IDLE;
            n_arg  = '0;
            n_exp  = 1'b0;
            n_long = 1'b0;
        end
    end

    assign o_st      = n_st;
    assign o_has_rsp = n_has;
    assign o_rsp     = '{cmd_index: n_idx, cmd_arg: n_arg, expect_resp: n_exp,
                         long_resp: n_long, finished: n_fin, status: n_status,
                         high_capacity: n_st.capacity_flag, card_rca: n_st.rca,
                         bus_wide: n_st.wide_flag};
endmodule
`default_nettype wire

// ===== rtl/sd_card_init_sequencer_top.sv =====
// an accepted word waits in the input register; its result is registered for o_rsp
// throughput: one word per cycle unless o_rsp stalls, set by the register pair
// a word that causes no result still advances through the step logic
// synchronous active-low reset clears the phase to idle, all card state to zero,
// the try count to 10 and the wide-bus enable to 0
`default_nettype none
module sd_card_init_sequencer_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    sdi_req_if.sink                              i_req,
    sdi_rsp_if.source                            o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [sdi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sdi_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sdi_pkg::*;

    t_cfg   r_cfg;
    t_state r_st;
    t_state n_st;
    t_req   w_word;
    logic   w_in_vld;
    logic   w_adv;
    t_rsp   n_rsp;
    logic   n_has;
    t_rsp   r_rsp;
    logic   r_out_vld;

    assign w_adv = w_in_vld && (!r_out_vld || o_rsp.ready);

    sdi_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_adv   (w_adv),
        .o_word  (w_word),
        .o_vld   (w_in_vld)
    );

    sdi_step u_step (
        .i_word    (w_word),
        .i_st      (r_st),
        .i_cfg     (r_cfg),
        .o_st      (n_st),
        .o_rsp     (n_rsp),
        .o_has_rsp (n_has)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{op_cond_tries: TRIES_RESET, wide_enable: 1'b0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OP_COND_TRIES: r_cfg.op_cond_tries <= i_cfg_data[TRIES_W-1:0];
                CFG_WIDE_ENABLE:   r_cfg.wide_enable   <= i_cfg_data[0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{phase: PH_IDLE, tries_left: '0, capacity_flag: 1'b0,
                      rca: '0, wide_flag: 1'b0};
        end else if (w_adv) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= n_has;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && n_has) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.cmd_index     = r_rsp.cmd_index;
    assign o_rsp.cmd_arg       = r_rsp.cmd_arg;
    assign o_rsp.expect_resp   = r_rsp.expect_resp;
    assign o_rsp.long_resp     = r_rsp.long_resp;
    assign o_rsp.finished      = r_rsp.finished;
    assign o_rsp.status        = r_rsp.status;
    assign o_rsp.high_capacity = r_rsp.high_capacity;
    assign o_rsp.card_rca      = r_rsp.card_rca;
    assign o_rsp.bus_wide      = r_rsp.bus_wide;

    a_fin_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_rsp.finished |-> r_rsp.cmd_index == CMD_GO_IDLE && !r_rsp.expect_resp)
        else $error("finished word carries a command");

    a_tries_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase == PH_OPC || r_st.phase == PH_APP |-> r_st.tries_left != '0)
        else $error("op-cond phase with no tries left");

    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_vld && !w_adv |=> w_in_vld && $stable(w_word))
        else $error("pending input word lost");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && n_has && n_rsp.finished |=> r_st.phase == PH_IDLE)
        else $error("sequence finished without returning to idle");

endmodule
`default_nettype wire

// ===== tb/sv/tb_sd_card_init_sequencer_top.sv =====
`default_nettype none
module tb_sd_card_init_sequencer_top;
    import sdi_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 300;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_WORDS = 235;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sdi_req_if req_ch();
    sdi_rsp_if rsp_ch();

    sd_card_init_sequencer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_req   pending_words[$];
    t_rsp   expected_cmds[$];
    t_req   offer_word;
    t_rsp   got_cmd;
    t_rsp   want_cmd;

    // shadow of the sequencer
    t_phase             sh_phase;
    logic [TRIES_W-1:0] sh_tries_left;
    logic               sh_capacity;
    logic [RCA_W-1:0]   sh_rca;
    logic               sh_wide;
    logic [TRIES_W-1:0] sh_cfg_tries;
    logic               sh_cfg_wide;

    int  mismatch_cnt;
    int  results_seen;
    int  hold_left;
    bit  hold_done;
    bit  calm;
    int  quiet_cycles;
    int  words_added;
    int  seq_budget;

    function automatic void step_sequencer(input t_req w);
        logic [31:0] r;
        logic [5:0]  idx;
        logic [31:0] arg;
        logic        er;
        logic        lr;
        logic        fin;
        logic [1:0]  st;
        bit          emit;
        r    = w.timed_out ? 32'd0 : w.resp_word;
        emit = 1'b1;
        idx  = CMD_GO_IDLE;
        arg  = 32'd0;
        er   = 1'b0;
        lr   = 1'b0;
        fin  = 1'b0;
        st   = ST_OK;
        if (w.req_type == REQ_START) begin
            sh_capacity   = 1'b0;
            sh_rca        = '0;
            sh_wide       = 1'b0;
            sh_tries_left = '0;
            sh_phase      = PH_CMD0;
        end else begin
            case (sh_phase)
                PH_CMD0: begin
                    sh_phase = PH_CMD8;
                    idx = CMD_IF_COND;
                    arg = IF_COND_ARG;
                    er  = 1'b1;
                end
                PH_CMD8: begin
                    sh_capacity = (r != 32'd0);
                    if (r != 32'd0 && r != IF_COND_ARG) begin
                        sh_phase = PH_IDLE;
                        fin = 1'b1;
                        st  = ST_VOLTAGE;
                    end else begin
                        sh_tries_left = (sh_cfg_tries == '0) ? TRIES_W'(1) : sh_cfg_tries;
                        sh_phase = PH_APP;
                        idx = CMD_APP;
                        er  = 1'b1;
                    end
                end
                PH_APP: begin
                    sh_phase = PH_OPC;
                    idx = CMD_OP_COND;
                    arg = sh_capacity ? (OCR_VOLTS | OCR_HCS_BIT) : OCR_VOLTS;
                    er  = 1'b1;
                end
                PH_OPC: begin
                    if (r[OCR_BUSY_POS]) begin
                        if (!r[OCR_HCS_POS]) sh_capacity = 1'b0;
                        sh_phase = PH_CID;
                        idx = CMD_ALL_CID;
                        er  = 1'b1;
                        lr  = 1'b1;
                    end else begin
                        if (sh_tries_left != '0) sh_tries_left = sh_tries_left - 1'b1;
                        if (sh_tries_left == '0) begin
                            sh_phase = PH_IDLE;
                            fin = 1'b1;
                            st  = ST_NO_READY;
                        end else begin
                            sh_phase = PH_APP;
                            idx = CMD_APP;
                            er  = 1'b1;
                        end
                    end
                end
                PH_CID: begin
                    sh_phase = PH_RCA;
                    idx = CMD_SEND_RCA;
                    er  = 1'b1;
                end
                PH_RCA: begin
                    sh_rca   = r[31:16];
                    sh_phase = PH_CSD;
                    idx = CMD_SEND_CSD;
                    arg = {sh_rca, 16'h0000};
                    er  = 1'b1;
                    lr  = 1'b1;
                end
                PH_CSD: begin
                    sh_phase = PH_SEL;
                    idx = CMD_SELECT;
                    arg = {sh_rca, 16'h0000};
                    er  = 1'b1;
                end
                PH_SEL: begin
                    if (sh_cfg_wide) begin
                        sh_phase = PH_WAPP;
                        idx = CMD_APP;
                        arg = {sh_rca, 16'h0000};
                        er  = 1'b1;
                    end else begin
                        sh_wide  = 1'b0;
                        sh_phase = PH_IDLE;
                        fin = 1'b1;
                    end
                end
                PH_WAPP: begin
                    sh_phase = PH_WBUS;
                    idx = CMD_SET_BUS;
                    arg = BUS4_ARG;
                    er  = 1'b1;
                end
                PH_WBUS: begin
                    sh_wide  = 1'b1;
                    sh_phase = PH_IDLE;
                    fin = 1'b1;
                end
                default: emit = 1'b0;
            endcase
        end
        if (emit) begin
            expected_cmds.push_back('{cmd_index: idx, cmd_arg: arg, expect_resp: er,
                                      long_resp: lr, finished: fin, status: st,
                                      high_capacity: sh_capacity, card_rca: sh_rca,
                                      bus_wide: sh_wide});
        end
    endfunction

    function automatic string fmt_cmd(input t_rsp c);
        return $sformatf("idx=%0d arg=%h er=%b lr=%b fin=%b st=%0d hc=%b rca=%h bw=%b",
                         c.cmd_index, c.cmd_arg, c.expect_resp, c.long_resp, c.finished,
                         c.status, c.high_capacity, c.card_rca, c.bus_wide);
    endfunction

    task automatic add_word(input logic rt, input logic to, input logic [31:0] resp);
        if (seq_budget > 0) begin
            seq_budget--;
            words_added++;
            pending_words.push_back('{req_type: rt, timed_out: to, resp_word: resp});
        end
    endtask

    // completion whose response the sequencer does not look at
    task automatic add_plain_done();
        add_word(REQ_DONE, $urandom_range(99) < 25, $urandom);
    endtask

    task automatic queue_bringup();
        int kind;
        int eff;
        int busy_n;
        logic [31:0] v;
        seq_budget = ($urandom_range(99) < 10) ? $urandom_range(1, 9) : 1000;
        add_word(REQ_START, 1'($urandom_range(1)), $urandom);
        add_plain_done();
        kind = $urandom_range(99);
        if (kind < 70) begin
            add_word(REQ_DONE, 1'b0, IF_COND_ARG);
        end else if (kind < 82) begin
            if ($urandom_range(1)) add_word(REQ_DONE, 1'b1, $urandom);
            else add_word(REQ_DONE, 1'b0, 32'd0);
        end else begin
            v = $urandom_range(1) ? $urandom : (IF_COND_ARG ^ (32'd1 << $urandom_range(31)));
            if (v == 32'd0 || v == IF_COND_ARG) v = 32'h0000_01AB;
            add_word(REQ_DONE, 1'b0, v);
            seq_budget = 1000;
            return;
        end
        eff  = (sh_cfg_tries == '0) ? 1 : int'(sh_cfg_tries);
        kind = $urandom_range(99);
        if (kind < 60) busy_n = $urandom_range(3);
        else if (kind < 85) busy_n = $urandom_range(eff);
        else busy_n = eff;
        if (busy_n > eff) busy_n = eff;
        for (int i = 0; i < eff; i++) begin
            add_plain_done();
            if (i < busy_n) begin
                if ($urandom_range(3) == 0) add_word(REQ_DONE, 1'b1, $urandom);
                else add_word(REQ_DONE, 1'b0, $urandom & 32'h7FFF_FFFF);
                if (i == eff - 1) begin
                    seq_budget = 1000;
                    return;
                end
            end else begin
                add_word(REQ_DONE, 1'b0, $urandom | 32'h8000_0000);
                break;
            end
        end
        add_plain_done();
        add_word(REQ_DONE, $urandom_range(9) == 0, $urandom);
        add_plain_done();
        add_plain_done();
        if (sh_cfg_wide) begin
            add_plain_done();
            add_plain_done();
        end
        seq_budget = 1000;
    endtask

    task automatic settle();
        while (pending_words.size() != 0 || req_ch.valid) @(posedge i_clk);
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [TRIES_W-1:0] tries, input logic wide);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_OP_COND_TRIES;
        cfg_data <= tries;
        @(posedge i_clk);
        cfg_idx  <= CFG_WIDE_ENABLE;
        cfg_data <= CFG_DATA_W'(wide);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sh_cfg_tries = tries;
        sh_cfg_wide  = wide;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid     <= 1'b0;
            req_ch.req_type  <= REQ_START;
            req_ch.timed_out <= 1'b0;
            req_ch.resp_word <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                step_sequencer('{req_type: req_ch.req_type, timed_out: req_ch.timed_out,
                                 resp_word: req_ch.resp_word});
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
                    offer_word = pending_words.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.req_type  <= offer_word.req_type;
                    req_ch.timed_out <= offer_word.timed_out;
                    req_ch.resp_word <= offer_word.resp_word;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got_cmd = '{cmd_index: rsp_ch.cmd_index, cmd_arg: rsp_ch.cmd_arg,
                            expect_resp: rsp_ch.expect_resp, long_resp: rsp_ch.long_resp,
                            finished: rsp_ch.finished, status: rsp_ch.status,
                            high_capacity: rsp_ch.high_capacity, card_rca: rsp_ch.card_rca,
                            bus_wide: rsp_ch.bus_wide};
                results_seen++;
                if (expected_cmds.size() == 0) begin
                    if (mismatch_cnt < 10) $display("unexpected word: %s", fmt_cmd(got_cmd));
                    mismatch_cnt++;
                end else begin
                    want_cmd = expected_cmds.pop_front();
                    if (got_cmd.cmd_index !== want_cmd.cmd_index ||
                        got_cmd.cmd_arg !== want_cmd.cmd_arg ||
                        got_cmd.expect_resp !== want_cmd.expect_resp ||
                        got_cmd.long_resp !== want_cmd.long_resp ||
                        got_cmd.finished !== want_cmd.finished ||
                        got_cmd.status !== want_cmd.status ||
                        got_cmd.high_capacity !== want_cmd.high_capacity ||
                        got_cmd.card_rca !== want_cmd.card_rca ||
                        got_cmd.bus_wide !== want_cmd.bus_wide) begin
                        if (mismatch_cnt < 10) begin
                            $display("word %0d mismatch", results_seen);
                            $display("  expected %s", fmt_cmd(want_cmd));
                            $display("  actual   %s", fmt_cmd(got_cmd));
                        end
                        mismatch_cnt++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= calm || $urandom_range(99) >= 36;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        logic [TRIES_W-1:0] tries_plan [NUM_PHASES];
        logic               wide_plan  [NUM_PHASES];
        tries_plan = '{4'd15, 4'd1, 4'd0, 4'd7, 4'd10, 4'd3, 4'd15, 4'd2};
        wide_plan  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        tries_plan[5] = TRIES_W'($urandom_range(15));
        wide_plan[5]  = 1'($urandom_range(1));

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_OP_COND_TRIES;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_START;
        req_ch.timed_out = 1'b0;
        req_ch.resp_word = '0;
        rsp_ch.ready     = 1'b0;
        sh_phase         = PH_IDLE;
        sh_tries_left    = '0;
        sh_capacity      = 1'b0;
        sh_rca           = '0;
        sh_wide          = 1'b0;
        sh_cfg_tries     = TRIES_RESET;
        sh_cfg_wide      = 1'b0;
        mismatch_cnt     = 0;
        results_seen     = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        calm             = 1'b0;
        quiet_cycles     = 0;
        words_added      = 0;
        seq_budget       = 1000;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: stray, restart, busy retry, high capacity, max rca
        add_word(REQ_DONE, 1'b0, 32'hFFFF_FFFF);
        add_word(REQ_START, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b1, 32'hFFFF_FFFF);
        add_word(REQ_START, 1'b1, 32'hFFFF_FFFF);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, IF_COND_ARG);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h7FFF_FFFF);
        add_word(REQ_DONE, 1'b0, 32'hFFFF_FFFF);
        add_word(REQ_DONE, 1'b0, 32'hC0FF_8000);
        add_word(REQ_DONE, 1'b0, 32'hFFFF_FFFF);
        add_word(REQ_DONE, 1'b0, 32'hFFFF_0000);
        add_word(REQ_DONE, 1'b1, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h1234_5678);
        // voltage mismatch
        add_word(REQ_START, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h0000_01AB);
        settle();

        // zero tries, wide bus
        set_config(4'd0, 1'b1);
        add_word(REQ_START, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b1, IF_COND_ARG);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h3FFF_FFFF);
        add_word(REQ_START, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h8000_0000);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'hA5A5_FFFF);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        add_word(REQ_DONE, 1'b0, 32'h0000_0000);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(tries_plan[p], wide_plan[p]);
            calm = (p == 4);
            words_added = 0;
            while (words_added < PHASE_WORDS) begin
                if ($urandom_range(99) < 88) begin
                    queue_bringup();
                end else begin
                    add_word($urandom_range(99) < 15 ? REQ_START : REQ_DONE,
                             1'($urandom_range(1)), $urandom);
                end
            end
            settle();
        end

        if (mismatch_cnt == 0 && expected_cmds.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
